// File: sv/sith_pkg.sv
// ============================================================================
// sith_pkg
// Shared constants, types and a hash helper for the string intern hash table.
// ============================================================================
package sith_pkg;

    localparam int TABLE_SLOTS_DEF   = 1024;
    localparam int MAX_KEY_BYTES_DEF = 32;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam int LOAD_DEN = 10;
    localparam int LOAD_NUM = 7;

    localparam int SLOT_INDEX_W = 10;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    // one FNV-1a step
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * HASH_PRIME;
    endfunction

endpackage

// File: sv/sith_ram.sv
// ============================================================================
// sith_ram
// Generic single-port synchronous RAM with registered read.
// ============================================================================
module sith_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/sith_key_buf.sv
// ============================================================================
// sith_key_buf
// Collects key bytes, keeps the running hash, length and overflow flag.
// ============================================================================
module sith_key_buf #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [7:0]                        i_byte,
    input  logic                              i_present,
    input  logic                              i_clear,
    input  logic [$clog2(MAX_KEY_BYTES)-1:0]  i_rd_idx,
    output logic [7:0]                        o_rd_byte,
    output logic [31:0]                       o_hash,
    output logic [$clog2(MAX_KEY_BYTES+1)-1:0] o_len,
    output logic                              o_overflow
);
    import sith_pkg::*;
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);
    localparam int IW = $clog2(MAX_KEY_BYTES);

    logic [7:0]    r_buf [MAX_KEY_BYTES];
    logic [31:0]   r_hash, n_hash;
    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;
    logic          full;

    assign full = (r_len == LW'(MAX_KEY_BYTES));

    always_comb begin
        n_hash = r_hash;
        n_len  = r_len;
        n_ovf  = r_ovf;
        if (i_clear) begin
            n_hash = HASH_BASIS;
            n_len  = '0;
            n_ovf  = 1'b0;
        end else if (i_take && i_present) begin
            n_hash = fnv_step(r_hash, i_byte);
            if (full) n_ovf = 1'b1;
            else      n_len = r_len + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_BASIS;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_hash <= n_hash;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
        end
    end

    // byte store, written at the current length, read at one index
    always_ff @(posedge i_clk) begin
        if (!i_clear && i_take && i_present && !full) begin
            r_buf[r_len[IW-1:0]] <= i_byte;
        end
    end

    assign o_rd_byte  = r_buf[i_rd_idx];
    assign o_hash     = r_hash;
    assign o_len      = r_len;
    assign o_overflow = r_ovf;
endmodule

// File: sv/string_intern_hash_table.sv
// ============================================================================
// string_intern_hash_table
// FNV-1a hashed, linear-probed intern table for byte-string keys.
// ============================================================================
// Usage: present one key byte per request on i_key_byte with i_byte_present,
// i_operation and i_last_byte, and raise start while busy is low. A request
// that is not the last of its key is taken without raising busy, and no
// result follows, so such requests may come back to back.
// At the last byte busy rises for the hash check state, the probe walk, any
// table write and the output state. A probe reads the slot meta entry; it
// ends at an empty slot, moves on when the stored length differs, and when
// the length matches compares the key bytes (the byte memory is read one
// byte a cycle). An insert writes one byte a cycle (only the meta entry for
// the empty key); a refused insert writes nothing. Too-long keys are not
// probed: their result comes after the check and output states.
// The result is on the o_ ports for one cycle with o_valid, in the first
// cycle with busy low again; the next request may be taken at its closing
// edge. The receiver cannot stall.
// After reset a clearing pass zeroes every entry of the slot meta memory,
// during which busy stays high.
// ============================================================================
module string_intern_hash_table #(
    parameter int TABLE_SLOTS   = sith_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_KEY_BYTES = sith_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [7:0]  i_key_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_inserted,
    output logic [sith_pkg::SLOT_INDEX_W-1:0] o_slot_index,
    output logic [31:0] o_key_hash
);
    import sith_pkg::*;

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int IW  = $clog2(MAX_KEY_BYTES);
    localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int CW  = SW + 1;
    localparam int BW  = SW + IW;
    localparam int LIMIT = (TABLE_SLOTS * LOAD_NUM) / LOAD_DEN;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_RD   = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_WR   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [SW-1:0] r_idx, n_idx, r_start;
    logic [CW-1:0] r_steps, n_steps;
    logic [IW-1:0] r_bi, n_bi;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_op;
    logic [1:0]    r_status, n_status;
    logic          r_ins, n_ins;
    logic          r_valid, n_valid;
    logic [SW-1:0] r_oslot, n_oslot;
    logic [31:0]   r_ohash;

    // compare pipeline: key byte delayed to line up with memory read data
    logic [7:0]    r_kb_byte_d;
    logic          r_done;
    logic [CW-1:0] r_cnt_e;

    logic take, kb_clear;
    logic [7:0] kb_byte;
    logic [31:0] kb_hash;
    logic [LW-1:0] kb_len;
    logic kb_ovf;

    // slot meta memory: {valid, length}
    logic          meta_we;
    logic [SW-1:0] meta_addr;
    logic [LW:0]   meta_wdata, meta_rdata;
    // byte memory, one key byte per entry
    logic          kw_we;
    logic [BW-1:0] kw_addr;
    logic [7:0]    kw_rdata;

    assign take = start && !busy;

    sith_key_buf #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_kb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_byte(i_key_byte), .i_present(i_byte_present), .i_clear(kb_clear),
        .i_rd_idx(r_bi), .o_rd_byte(kb_byte), .o_hash(kb_hash),
        .o_len(kb_len), .o_overflow(kb_ovf)
    );

    sith_ram #(.WIDTH(LW + 1), .DEPTH(TABLE_SLOTS)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_addr(meta_addr),
        .i_wdata(meta_wdata), .o_rdata(meta_rdata)
    );

    sith_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS * MAX_KEY_BYTES)) u_kw (
        .i_clk(i_clk), .i_we(kw_we), .i_addr(kw_addr),
        .i_wdata(kb_byte), .o_rdata(kw_rdata)
    );

    logic last_bi;
    assign last_bi = ({1'b0, r_bi} == (kb_len - LW'(1)));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_steps  = r_steps;
        n_bi     = r_bi;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_ins    = r_ins;
        n_valid  = 1'b0;
        n_oslot  = r_oslot;
        kb_clear = 1'b0;
        meta_we  = 1'b0;
        meta_addr  = r_idx;
        meta_wdata = '0;
        kw_we    = 1'b0;
        kw_addr  = {r_idx, r_bi};
        unique case (r_state)
            S_CLR: begin
                meta_we = 1'b1;
                n_idx   = r_idx + SW'(1);
                if (r_idx == SW'(TABLE_SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take && i_last_byte) n_state = S_CHK;
            end
            S_CHK: begin
                // registers now include last byte
                if (kb_ovf) begin
                    n_status = ST_TOO_LONG;
                    n_ins    = 1'b0;
                    n_oslot  = '0;
                    n_state  = S_OUT;
                end else begin
                    n_idx   = kb_hash[SW-1:0];
                    n_steps = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_bi = '0;
                // meta read issued at r_idx, data next cycle in S_CMP
                n_state = S_CMP;
                n_cnt   = '0;
            end
            S_CMP: begin
                // r_cnt 0: meta data valid; byte reads streamed at r_bi
                if (r_cnt == '0) begin
                    if (!meta_rdata[LW]) begin
                        n_oslot = r_idx;
                        if (r_op) n_state = S_WR;
                        else begin
                            n_status = ST_NOT_FOUND;
                            n_ins    = 1'b0;
                            n_state  = S_OUT;
                        end
                        n_bi = '0;
                    end else if (meta_rdata[LW-1:0] != kb_len) begin
                        n_state = S_RD;
                        n_idx   = r_idx + SW'(1);
                        n_steps = r_steps + CW'(1);
                    end else if (kb_len == '0) begin
                        n_status = ST_FOUND;
                        n_ins    = 1'b0;
                        n_oslot  = r_idx;
                        n_state  = S_OUT;
                    end else begin
                        n_cnt = CW'(1); // byte 0 read now issued
                    end
                end else if (r_cnt == CW'(1)) begin
                    n_cnt = CW'(2);
                    if (!last_bi) n_bi = r_bi + IW'(1);
                end else begin
                    // kw_rdata holds byte for r_bi-1 or final
                    if (kw_rdata != r_kb_byte_d) begin
                        n_state = S_RD;
                        n_idx   = r_idx + SW'(1);
                        n_steps = r_steps + CW'(1);
                    end else if (r_done) begin
                        n_status = ST_FOUND;
                        n_ins    = 1'b0;
                        n_oslot  = r_idx;
                        n_state  = S_OUT;
                    end else if (!last_bi) begin
                        n_bi = r_bi + IW'(1);
                    end
                end
                if (n_state == S_RD && r_steps == CW'(TABLE_SLOTS - 1)) begin
                    n_oslot = r_start;
                    if (r_op) n_state = S_WR;
                    else begin
                        n_status = ST_NOT_FOUND;
                        n_ins    = 1'b0;
                        n_state  = S_OUT;
                    end
                    n_idx   = r_start;
                    n_steps = CW'(TABLE_SLOTS);
                    n_bi    = '0;
                end
            end
            S_WR: begin
                if (r_steps == CW'(TABLE_SLOTS) ||
                    r_cnt_e >= CW'(LIMIT)) begin
                    n_status = ST_FULL;
                    n_ins    = 1'b0;
                    n_state  = S_OUT;
                end else begin
                    kw_we   = (kb_len != '0);
                    kw_addr = {r_oslot, r_bi};
                    if (kb_len == '0 || last_bi) begin
                        meta_we    = 1'b1;
                        meta_addr  = r_oslot;
                        meta_wdata = {1'b1, kb_len};
                        n_status   = ST_NOT_FOUND;
                        n_ins      = 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        n_bi = r_bi + IW'(1);
                    end
                end
            end
            S_OUT: begin
                n_valid  = 1'b1;
                kb_clear = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_kb_byte_d <= kb_byte;
        r_done      <= last_bi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_cnt_e <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            if (r_state == S_WR && n_ins && n_state == S_OUT) r_cnt_e <= r_cnt_e + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps  <= n_steps;
        r_bi     <= n_bi;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_ins    <= n_ins;
        r_oslot  <= n_oslot;
        if (r_state == S_CHK) r_start <= kb_hash[SW-1:0];
        if (take && i_last_byte) r_op <= i_operation;
        if (r_state == S_CHK) r_ohash <= kb_hash;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_inserted  = r_ins;
    assign o_slot_index = SLOT_INDEX_W'(r_oslot);
    assign o_key_hash  = r_ohash;
endmodule

// File: sv/sith_checker.sv
// ============================================================================
// sith_checker
// Port-level checks for the string intern hash table.
// ============================================================================
module sith_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_status,
    input logic       o_inserted
);
    import sith_pkg::*;

    a_ins_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inserted |-> o_status == ST_NOT_FOUND)
        else $error("inserted with wrong status");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result repeated");

    a_rst_busy: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> busy)
        else $error("not clearing after reset");
endmodule

bind string_intern_hash_table sith_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_valid(o_valid), .o_status(o_status), .o_inserted(o_inserted)
);

// File: bench/string_intern_hash_table_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// string_intern_hash_table_tb
// Self-checking bench for the intern table. Keys are sent one byte per
// request. A scoreboard class keeps its own FNV-1a hash, key buffer and slot
// table, and works out the expected result at each key end. Each strobed
// result is checked field by field against the oldest expectation.
// ============================================================================
import sith_pkg::*;

typedef struct {
    t_status     status;
    logic        inserted;
    logic [9:0]  slot;
    logic [31:0] hash;
} t_intern_result;

typedef struct {
    int         len;
    logic [7:0] bytes [0:39];
} t_key;

class intern_scoreboard;
    localparam int SLOTS   = 1024;
    localparam int MAXLEN  = 32;

    logic [31:0] hash_acc;
    logic [7:0]  key_buf [0:MAXLEN-1];
    int          key_len;
    bit          key_over;
    bit          tab_valid [0:SLOTS-1];
    int          tab_len   [0:SLOTS-1];
    logic [7:0]  tab_bytes [0:SLOTS-1][0:MAXLEN-1];
    int          entries;
    t_intern_result pending_results [$];
    int          mismatches;
    int          n_checked;
    int          n_status [0:3];
    int          n_inserted;

    function new();
        hash_acc = HASH_BASIS;
        key_len = 0;
        key_over = 0;
        entries = 0;
        mismatches = 0;
        n_checked = 0;
        n_inserted = 0;
        foreach (tab_valid[i]) tab_valid[i] = 0;
        foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function bit slot_holds_key(int s);
        if (tab_len[s] != key_len) return 0;
        for (int i = 0; i < key_len; i++)
            if (tab_bytes[s][i] != key_buf[i]) return 0;
        return 1;
    endfunction

    // note one accepted request; push the expected result at key end
    function void note_request(logic op, logic [7:0] b, logic present, logic last);
        t_intern_result r;
        int first, idx;
        bit hit, hole;
        if (present) begin
            hash_acc = (hash_acc ^ {24'd0, b}) * HASH_PRIME;
            if (key_len < MAXLEN) begin
                key_buf[key_len] = b;
                key_len++;
            end else
                key_over = 1;
        end
        if (!last) return;
        r.hash = hash_acc;
        r.inserted = 0;
        if (key_over) begin
            r.status = ST_TOO_LONG;
            r.slot = '0;
        end else begin
            first = hash_acc[9:0];
            idx = first;
            hit = 0;
            hole = 0;
            for (int n = 0; n < SLOTS; n++) begin
                if (!tab_valid[idx]) begin
                    hole = 1;
                    break;
                end
                if (slot_holds_key(idx)) begin
                    hit = 1;
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
            if (!hit && !hole) idx = first;
            r.status = ST_NOT_FOUND;
            if (hit)
                r.status = ST_FOUND;
            else if (op) begin
                if ((entries + 1) * LOAD_DEN > SLOTS * LOAD_NUM || !hole)
                    r.status = ST_FULL;
                else begin
                    tab_valid[idx] = 1;
                    tab_len[idx] = key_len;
                    for (int i = 0; i < key_len; i++) tab_bytes[idx][i] = key_buf[i];
                    entries++;
                    r.inserted = 1;
                end
            end
            r.slot = idx[9:0];
        end
        pending_results.push_back(r);
        hash_acc = HASH_BASIS;
        key_len = 0;
        key_over = 0;
    endfunction

    function void check_result(logic [1:0] st, logic ins, logic [9:0] slot, logic [31:0] h);
        t_intern_result e;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result: status %0d ins %0d slot %0d hash %08h",
                         $time, st, ins, slot, h);
            return;
        end
        e = pending_results.pop_front();
        n_checked++;
        n_status[e.status]++;
        n_inserted += e.inserted;
        if (st !== e.status || ins !== e.inserted || slot !== e.slot || h !== e.hash) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"[%0t] result mismatch: exp st %0d ins %0d slot %0d hash %08h,",
                          " got st %0d ins %0d slot %0d hash %08h"},
                         $time, e.status, e.inserted, e.slot, e.hash, st, ins, slot, h);
        end
    endfunction
endclass

module string_intern_hash_table_tb;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_REQS  = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [7:0]  i_key_byte;
    logic        i_byte_present;
    logic        i_last_byte;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_inserted;
    logic [SLOT_INDEX_W-1:0] o_slot_index;
    logic [31:0] o_key_hash;

    intern_scoreboard sb;
    t_key        seen_keys [$];
    int          cycle_count = 0;
    int          req_count;

    string_intern_hash_table dut (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_key_byte,
        .i_byte_present, .i_last_byte, .o_valid, .o_status, .o_inserted,
        .o_slot_index, .o_key_hash
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_status, o_inserted, o_slot_index, o_key_hash);
    end

    // one request; start stays high across back-to-back requests
    task automatic send_request(logic op, logic [7:0] b, logic present, logic last);
        int gap;
        start <= 1'b1;
        i_operation <= op;
        i_key_byte <= b;
        i_byte_present <= present;
        i_last_byte <= last;
        do @(posedge i_clk); while (busy);
        sb.note_request(op, b, present, last);
        req_count++;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_key(logic op, t_key k, bit noise);
        if (k.len == 0) begin
            send_request(op, 8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < k.len; i++) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_request(1'($urandom), 8'($urandom), 1'b0, 1'b0);
            // operation on bytes before the last is ignored
            send_request(i == k.len - 1 ? op : 1'($urandom), k.bytes[i], 1'b1,
                         i == k.len - 1);
        end
        if (k.len <= 32) seen_keys.push_back(k);
    endtask

    function automatic t_key random_key(int len);
        t_key k;
        k.len = len;
        for (int i = 0; i < 40; i++) k.bytes[i] = 8'($urandom);
        return k;
    endfunction

    // distinct short keys: one byte below 256, two bytes from 256 up
    function automatic t_key fill_key(int n);
        t_key k;
        if (n < 256) begin
            k.len = 1;
            k.bytes[0] = n[7:0];
        end else begin
            k.len = 2;
            k.bytes[0] = n[15:8];
            k.bytes[1] = n[7:0];
        end
        return k;
    endfunction

    initial begin
        t_key k;
        int len, sel, fill_n;
        sb = new();
        req_count = 0;
        start = 0;
        i_operation = 0;
        i_key_byte = 0;
        i_byte_present = 0;
        i_last_byte = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty key, extremes of bytes, long keys, ignored items
        k.len = 0;
        send_key(1'b0, k, 0);
        send_key(1'b1, k, 0);
        send_key(1'b1, k, 0);
        k = random_key(1); k.bytes[0] = 8'h00;
        send_key(1'b0, k, 0);
        send_key(1'b1, k, 0);
        send_key(1'b0, k, 0);
        k.bytes[0] = 8'hFF;
        send_key(1'b1, k, 0);
        send_key(1'b1, k, 0);
        send_request(1'b1, 8'h55, 1'b0, 1'b0);
        send_request(1'b0, 8'hAA, 1'b0, 1'b0);
        k = random_key(32);
        send_key(1'b1, k, 0);
        send_key(1'b0, k, 0);
        k = random_key(33);
        send_key(1'b1, k, 0);

        // random: mostly new or repeated short keys, some long, a little noise
        while (req_count < RANDOM_REQS) begin
            sel = $urandom_range(0, 99);
            if (sel < 30 && seen_keys.size() > 0)
                k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            else begin
                len = $urandom_range(0, 99);
                if (len < 3) len = $urandom_range(33, 36);
                else if (len < 10) len = $urandom_range(5, 32);
                else if (len < 12) len = 0;
                else len = $urandom_range(1, 4);
                k = random_key(len);
            end
            send_key($urandom_range(0, 3) != 0, k, 1);
        end

        // fill the table up to its load limit, then push past it
        fill_n = 0;
        while (sb.entries < 716 && fill_n < 4000) begin
            send_key(1'b1, fill_key(fill_n), 0);
            fill_n++;
        end
        repeat (6) send_key(1'b1, fill_key(fill_n + $urandom_range(0, 1000)), 1);
        repeat (20) begin
            k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            send_key(1'($urandom), k, 1);
            send_key(1'($urandom), random_key($urandom_range(1, 6)), 1);
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d requests, %0d results checked (%0d inserted), %0d entries in table",
                 req_count, sb.n_checked, sb.n_inserted, sb.entries);
        $display("status seen: found %0d, not found %0d, full %0d, too long %0d; %0d mismatches",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: filelist.f
sv/sith_pkg.sv
sv/sith_ram.sv
sv/sith_key_buf.sv
sv/string_intern_hash_table.sv
sv/sith_checker.sv
bench/string_intern_hash_table_tb.sv
